// File: hw/rtl/decimal_float_literal_recognizer_assert.svh
// Assertion macros for the decimal float literal recognizer.
// Used by files that `include this header; needs a clk and an rst_n in scope.
`ifndef DECIMAL_FLOAT_LITERAL_RECOGNIZER_ASSERT_SVH
`define DECIMAL_FLOAT_LITERAL_RECOGNIZER_ASSERT_SVH
`ifndef SYNTH
// Checked property, disabled while reset is active.
`define DFLR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked property, also checked during reset.
`define DFLR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DFLR_ASSERT(lbl, prop, msg)
`define DFLR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/dflr_pkg.sv
// Package for the decimal float literal recogniser: character codes,
// slot class and exponent phase types. No dependencies.
`default_nettype none

package dflr_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Consumed count saturates one above the longest literal
    localparam int unsigned COUNT_W = 9;

    typedef enum logic [2:0] {
        CLS_NUM   = 3'd1,
        CLS_DOT   = 3'd2,
        CLS_EXP   = 3'd3,
        CLS_MINUS = 3'd4,
        CLS_PLUS  = 3'd5
    } slot_cls_t;

    typedef enum logic [1:0] {
        PH_NORMAL      = 2'd0,
        PH_AFTER_EXP   = 2'd1,
        PH_AFTER_MINUS = 2'd2
    } exp_phase_t;

endpackage

`default_nettype wire

// File: hw/rtl/decimal_float_literal_recognizer.sv
// Decimal float literal recogniser: streaming lexer, one character per transaction.
// Depends on dflr_pkg and decimal_float_literal_recognizer_assert.svh.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_stall, ch, start_req     | into block
//  output  | out_valid, out_stall, literal_len,    | out of block
//          | matched, too_long                     |
//
// Takes one character every cycle while no terminator waits on a stalled result.
// A transaction lands in the input register, then the scan state update and the
// slot pattern check run in one pass into the result register. Reset clears the
// scan state and both valid flags; class slots are not reset. A stalled result
// holds the output register; only a terminator waiting on it holds the input
// register, other characters keep flowing.
`default_nettype none

module decimal_float_literal_recognizer
    import dflr_pkg::*;
#(
    parameter int unsigned PATTERN_SLOTS = 6
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] ch,
    input  wire logic       start_req,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      literal_len,
    output logic            matched,
    output logic            too_long
);

    localparam int unsigned IDX_W = $clog2(PATTERN_SLOTS);
    localparam int unsigned CNT_W = $clog2(PATTERN_SLOTS + 2);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(PATTERN_SLOTS);

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_ch_reg;
    logic       s1_start_reg;

    // Scan state
    logic               scanning_reg, scanning_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    exp_phase_t         phase_reg, phase_next;
    logic               prev_digit_reg, prev_digit_next;
    logic [CNT_W-1:0]   slot_count_reg, slot_count_next;
    logic               has_dot_reg, has_dot_next;
    logic [IDX_W-1:0]   dot_idx_reg, dot_idx_next;
    logic               has_exp_reg, has_exp_next;
    logic [IDX_W-1:0]   exp_idx_reg, exp_idx_next;
    slot_cls_t          class_slots_reg [PATTERN_SLOTS];

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_len_reg;
    logic       out_matched_reg;
    logic       out_too_long_reg;

    // Effective state seen by the character in the input register
    logic               eff_prev_digit;
    logic [COUNT_W-1:0] eff_count;
    exp_phase_t         eff_phase;
    logic [CNT_W-1:0]   eff_n;
    logic               eff_has_dot;
    logic [IDX_W-1:0]   eff_dot;
    logic               eff_has_exp;
    logic [IDX_W-1:0]   eff_exp;

    logic       s1_live;
    logic       s1_result;
    logic       s1_fire;
    logic       out_free;
    logic       is_digit;
    logic       is_sign_slot;
    logic       slot_we;
    logic [IDX_W-1:0] slot_widx;
    slot_cls_t  slot_wcls;

    // Pattern check
    logic [CNT_W-1:0] ex;
    logic [CNT_W-1:0] ex_p1;
    logic [CNT_W-1:0] ex_p2;
    logic [CNT_W-1:0] dot_ext;
    logic             bad_prefix;
    slot_cls_t        after_exp1;
    slot_cls_t        after_exp2;
    logic             pat_ok;
    logic             res_too_long;
    logic             res_ok;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_live   = s1_valid_reg && (s1_start_reg || scanning_reg);
    // Terminator waits for a free result register; anything else moves on
    assign s1_fire   = s1_valid_reg && (!s1_result || out_free);
    assign in_stall  = s1_valid_reg && !s1_fire;

    assign out_valid   = out_valid_reg;
    assign literal_len = out_len_reg;
    assign matched     = out_matched_reg;
    assign too_long    = out_too_long_reg;

    // A start character sees a freshly cleared scan
    always_comb
    begin
        if (s1_start_reg)
        begin
            eff_prev_digit = 1'b0;
            eff_count      = '0;
            eff_phase      = PH_NORMAL;
            eff_n          = '0;
            eff_has_dot    = 1'b0;
            eff_dot        = '0;
            eff_has_exp    = 1'b0;
            eff_exp        = '0;
        end
        else
        begin
            eff_prev_digit = prev_digit_reg;
            eff_count      = count_reg;
            eff_phase      = phase_reg;
            eff_n          = slot_count_reg;
            eff_has_dot    = has_dot_reg;
            eff_dot        = dot_idx_reg;
            eff_has_exp    = has_exp_reg;
            eff_exp        = exp_idx_reg;
        end
    end

    // Slot pattern check over the effective state
    always_comb
    begin
        ex      = eff_has_exp ? CNT_W'(eff_exp) : eff_n;
        ex_p1   = ex + CNT_W'(1);
        ex_p2   = ex + CNT_W'(2);
        dot_ext = CNT_W'(eff_dot);
        bad_prefix = 1'b0;
        after_exp1 = CLS_DOT;
        after_exp2 = CLS_DOT;
        for (int j = 0; j < PATTERN_SLOTS; j++)
        begin
            if (class_slots_reg[j] != CLS_NUM
                && !(eff_has_dot && eff_dot == IDX_W'(j))
                && (CNT_W'(j) < ex || (eff_has_dot && CNT_W'(j) < dot_ext)))
            begin
                bad_prefix = 1'b1;
            end
            if (CNT_W'(j) == ex_p1)
            begin
                after_exp1 = class_slots_reg[j];
            end
            if (CNT_W'(j) == ex_p2)
            begin
                after_exp2 = class_slots_reg[j];
            end
        end
        pat_ok = (eff_n <= SLOTS_C) && (ex != '0) && (ex_p1 != eff_n) && !bad_prefix
                 && ((ex == eff_n) || (after_exp1 == CLS_NUM)
                     || ((ex_p2 < eff_n)
                         && (after_exp1 == CLS_MINUS || after_exp1 == CLS_PLUS)
                         && after_exp2 == CLS_NUM));
        res_too_long = eff_count[COUNT_W-1];
        res_ok       = !res_too_long && pat_ok;
    end

    // Scan state update for the character in the input register
    always_comb
    begin
        scanning_next   = scanning_reg;
        count_next      = count_reg;
        phase_next      = phase_reg;
        prev_digit_next = prev_digit_reg;
        slot_count_next = slot_count_reg;
        has_dot_next    = has_dot_reg;
        dot_idx_next    = dot_idx_reg;
        has_exp_next    = has_exp_reg;
        exp_idx_next    = exp_idx_reg;
        slot_we         = 1'b0;
        slot_wcls       = CLS_NUM;
        s1_result       = 1'b0;

        is_digit     = (s1_ch_reg >= CH_ZERO) && (s1_ch_reg <= CH_NINE);
        is_sign_slot = (eff_phase == PH_AFTER_EXP
                        && (s1_ch_reg == CH_MINUS || s1_ch_reg == CH_PLUS))
                       || (eff_phase == PH_AFTER_MINUS && s1_ch_reg == CH_PLUS);
        slot_widx    = eff_n[IDX_W-1:0];

        if (s1_live)
        begin
            // Take the character by default: start from the effective state
            scanning_next   = 1'b1;
            count_next      = eff_count[COUNT_W-1] ? eff_count : eff_count + COUNT_W'(1);
            phase_next      = PH_NORMAL;
            prev_digit_next = 1'b0;
            slot_count_next = (eff_n <= SLOTS_C) ? eff_n + CNT_W'(1) : eff_n;
            has_dot_next    = eff_has_dot;
            dot_idx_next    = eff_dot;
            has_exp_next    = eff_has_exp;
            exp_idx_next    = eff_exp;
            slot_we         = eff_n < SLOTS_C;

            if (s1_start_reg && s1_ch_reg == CH_MINUS)
            begin
                // Leading minus: counted, no slot
                slot_count_next = eff_n;
                slot_we         = 1'b0;
            end
            else if (is_sign_slot)
            begin
                slot_wcls  = (s1_ch_reg == CH_MINUS) ? CLS_MINUS : CLS_PLUS;
                phase_next = (s1_ch_reg == CH_MINUS) ? PH_AFTER_MINUS : PH_NORMAL;
            end
            else if (is_digit)
            begin
                prev_digit_next = 1'b1;
                slot_wcls       = CLS_NUM;
                if (eff_prev_digit)
                begin
                    // Digit run continues in the same slot
                    slot_count_next = eff_n;
                    slot_we         = 1'b0;
                end
            end
            else if (s1_ch_reg == CH_DOT)
            begin
                slot_wcls = CLS_DOT;
                if (eff_n < SLOTS_C)
                begin
                    has_dot_next = 1'b1;
                    dot_idx_next = slot_widx;
                end
            end
            else if (s1_ch_reg == CH_E_LO || s1_ch_reg == CH_E_UP)
            begin
                slot_wcls  = CLS_EXP;
                phase_next = PH_AFTER_EXP;
                if (eff_n < SLOTS_C)
                begin
                    has_exp_next = 1'b1;
                    exp_idx_next = slot_widx;
                end
            end
            else
            begin
                // Terminator: drop the scan, emit the result
                s1_result       = 1'b1;
                scanning_next   = 1'b0;
                count_next      = eff_count;
                prev_digit_next = eff_prev_digit;
                slot_count_next = eff_n;
                slot_we         = 1'b0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (s1_fire && s1_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            scanning_reg   <= 1'b0;
            count_reg      <= '0;
            phase_reg      <= PH_NORMAL;
            prev_digit_reg <= 1'b0;
            slot_count_reg <= '0;
            has_dot_reg    <= 1'b0;
            dot_idx_reg    <= '0;
            has_exp_reg    <= 1'b0;
            exp_idx_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                scanning_reg   <= scanning_next;
                count_reg      <= count_next;
                phase_reg      <= phase_next;
                prev_digit_reg <= prev_digit_next;
                slot_count_reg <= slot_count_next;
                has_dot_reg    <= has_dot_next;
                dot_idx_reg    <= dot_idx_next;
                has_exp_reg    <= has_exp_next;
                exp_idx_reg    <= exp_idx_next;
            end
        end
    end

    // Payload registers: input, class slots and result
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_ch_reg    <= ch;
            s1_start_reg <= start_req;
        end
        if (s1_fire && slot_we)
        begin
            class_slots_reg[slot_widx] <= slot_wcls;
        end
        if (s1_fire && s1_result)
        begin
            out_len_reg      <= res_ok ? eff_count[7:0] : 8'd0;
            out_matched_reg  <= res_ok;
            out_too_long_reg <= res_too_long;
        end
    end

`include "decimal_float_literal_recognizer_assert.svh"

    `DFLR_ASSERT(a_match_has_len, out_valid_reg && out_matched_reg |-> out_len_reg != 8'd0 && !out_too_long_reg, "matched result with zero length or overlong")
    `DFLR_ASSERT(a_long_rejected, out_valid_reg && out_too_long_reg |-> out_len_reg == 8'd0 && !out_matched_reg, "overlong scan reported a length")
    `DFLR_ASSERT(a_slot_count_sat, slot_count_reg <= SLOTS_C + CNT_W'(1), "slot count beyond saturation")
    `DFLR_ASSERT(a_result_loaded, s1_fire && s1_result |=> out_valid_reg, "terminator fired but no result registered")
    `DFLR_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> s1_valid_reg, "input stalled with empty input register")

endmodule

`default_nettype wire

// File: tb/sv/tb_decimal_float_literal_recognizer.sv
// Self-checking testbench for decimal_float_literal_recognizer: directed table, long literals,
// then random literal-shaped character streams, checked against a local lexer model or typed rows.
// Depends on dflr_pkg and the RTL of decimal_float_literal_recognizer.
`default_nettype none

module tb_decimal_float_literal_recognizer;
    timeunit 1ns;
    timeprecision 1ps;

    import dflr_pkg::*;

    localparam int unsigned PATTERN_SLOTS = 6;
    localparam int unsigned MAX_LEN       = 255;
    localparam logic [3:0]  NONE_SLOT     = 4'd15;
    localparam logic [7:0]  CH_NUL        = 8'h00;
    localparam logic [7:0]  CH_DIGIT_1    = 8'h31;
    localparam logic [7:0]  CH_DIGIT_3    = 8'h33;
    localparam logic [7:0]  CH_DIGIT_5    = 8'h35;
    localparam logic [7:0]  CH_DIGIT_7    = 8'h37;
    localparam logic [7:0]  CH_LETTER_X   = 8'h78;
    localparam logic [7:0]  CH_SPACE      = 8'h20;
    localparam logic [7:0]  CH_ALL_ONES   = 8'hFF;
    localparam int          RANDOM_ITEMS  = 500;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [7:0] len;
        logic       matched;
        logic       too_long;
    } lit_result_t;

    // One row of the directed table; a typed expectation replaces the lexer model's
    typedef struct packed {
        logic [7:0] ch;
        logic       st;
        logic       typed;
        logic [7:0] len;
        logic       matched;
        logic       too_long;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] ch = 8'h00;
    logic       start_req = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] literal_len;
    logic       matched;
    logic       too_long;

    // Lexer model state
    logic             lx_scanning;
    logic [8:0]       lx_count;
    exp_phase_t       lx_phase;
    logic             lx_prev_digit;
    logic [2:0]       lx_slots [PATTERN_SLOTS];
    logic [3:0]       lx_nslots;
    logic [3:0]       lx_dot_slot;
    logic [3:0]       lx_exp_slot;

    lit_result_t      expected_literals [$];
    dir_row_t         dir_rows [DIRECTED_ROWS];

    int  errors       = 0;
    int  n_live       = 0;
    int  n_results    = 0;
    int  n_accepted   = 0;
    int  n_overlong   = 0;
    int  cycle_count  = 0;
    int  burst_left   = 0;
    logic hold_req    = 1'b0;

    decimal_float_literal_recognizer #(
        .PATTERN_SLOTS(PATTERN_SLOTS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .start_req  (start_req),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .literal_len(literal_len),
        .matched    (matched),
        .too_long   (too_long)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------

    task automatic clear_scan();
        lx_count      = '0;
        lx_phase      = PH_NORMAL;
        lx_prev_digit = 1'b0;
        lx_nslots     = '0;
        lx_dot_slot   = NONE_SLOT;
        lx_exp_slot   = NONE_SLOT;
    endtask

    // Count one consumed character, saturating one above the longest literal
    task automatic take_char();
        if (lx_count <= MAX_LEN)
            lx_count = lx_count + 9'd1;
    endtask

    // Record a slot class; the count runs one past the table so overflow is seen
    task automatic put_slot(input logic [2:0] cls);
        if (lx_nslots < PATTERN_SLOTS)
            lx_slots[lx_nslots] = cls;
        if (lx_nslots <= PATTERN_SLOTS)
            lx_nslots = lx_nslots + 4'd1;
    endtask

    function automatic logic [2:0] slot_at(input int j);
        return (j < PATTERN_SLOTS) ? lx_slots[j] : 3'd0;
    endfunction

    // Check the recorded slot pattern against the acceptance rules
    function automatic bit pattern_valid();
        int n;
        int ex;
        int lo;
        logic [2:0] a;
        n = lx_nslots;
        if (n > PATTERN_SLOTS)
            return 1'b0;
        ex = (lx_exp_slot == NONE_SLOT || lx_exp_slot >= n) ? n : int'(lx_exp_slot);
        if (ex == 0 || ex + 1 == n)
            return 1'b0;
        lo = 0;
        if (lx_dot_slot != NONE_SLOT && lx_dot_slot < n)
        begin
            for (int j = 0; j < int'(lx_dot_slot); j++)
                if (slot_at(j) != CLS_NUM)
                    return 1'b0;
            lo = int'(lx_dot_slot) + 1;
        end
        for (int j = lo; j < ex; j++)
            if (slot_at(j) != CLS_NUM)
                return 1'b0;
        if (ex == n)
            return 1'b1;
        a = slot_at(ex + 1);
        if (a == CLS_NUM)
            return 1'b1;
        return (ex + 2 < n) && (a == CLS_MINUS || a == CLS_PLUS) && (slot_at(ex + 2) == CLS_NUM);
    endfunction

    // Advance the lexer model by one character; got is set when a scan ends here
    task automatic lex_char(input logic [7:0] c, input logic s, output bit got,
                            output lit_result_t r);
        bit tl;
        bit ok;
        got = 1'b0;
        r   = '0;
        if (s)
        begin
            lx_scanning = 1'b1;
            clear_scan();
            if (c == CH_MINUS)
            begin
                take_char();
                return;
            end
        end
        else if (!lx_scanning)
            return;

        if ((lx_phase == PH_AFTER_EXP && (c == CH_MINUS || c == CH_PLUS)) ||
            (lx_phase == PH_AFTER_MINUS && c == CH_PLUS))
        begin
            take_char();
            if (c == CH_MINUS)
            begin
                put_slot(CLS_MINUS);
                lx_phase = PH_AFTER_MINUS;
            end
            else
            begin
                put_slot(CLS_PLUS);
                lx_phase = PH_NORMAL;
            end
            lx_prev_digit = 1'b0;
            return;
        end
        lx_phase = PH_NORMAL;

        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            take_char();
            if (!lx_prev_digit)
                put_slot(CLS_NUM);
            lx_prev_digit = 1'b1;
            return;
        end
        if (c == CH_DOT)
        begin
            take_char();
            if (lx_nslots < PATTERN_SLOTS)
                lx_dot_slot = lx_nslots;
            put_slot(CLS_DOT);
            lx_prev_digit = 1'b0;
            return;
        end
        if (c == CH_E_LO || c == CH_E_UP)
        begin
            take_char();
            if (lx_nslots < PATTERN_SLOTS)
                lx_exp_slot = lx_nslots;
            put_slot(CLS_EXP);
            lx_prev_digit = 1'b0;
            lx_phase = PH_AFTER_EXP;
            return;
        end

        // Any other character ends the scan without being consumed
        lx_scanning = 1'b0;
        tl          = lx_count > MAX_LEN;
        ok          = !tl && pattern_valid();
        r.len       = ok ? lx_count[7:0] : 8'd0;
        r.matched   = ok;
        r.too_long  = tl;
        got         = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic bit is_scan_char(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_E_LO ||
               c == CH_E_UP || c == CH_MINUS || c == CH_PLUS;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    // Pick a character that ends a scan: NUL three times in ten, otherwise any non-literal byte
    function automatic logic [7:0] pick_stop();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 30)
            return CH_NUL;
        do
            c = 8'($urandom_range(0, 255));
        while (is_scan_char(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_scan_char();
        case ($urandom_range(0, 5))
            0: return rand_digit();
            1: return CH_DOT;
            2: return CH_E_LO;
            3: return CH_E_UP;
            4: return CH_MINUS;
            default: return CH_PLUS;
        endcase
    endfunction

    // Offer one transaction and hold it until accepted, then predict and maybe idle.
    // A typed expectation, where given, stands in for the lexer model's result.
    task automatic send_char(input logic [7:0] c, input logic s,
                             input bit fixed = 1'b0, input lit_result_t fixed_res = '0);
        bit          got;
        lit_result_t r;
        int          gap;
        in_valid  <= 1'b1;
        ch        <= c;
        start_req <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (s || lx_scanning)
            n_live++;
        lex_char(c, s, got, r);
        if (got)
            expected_literals.push_back(fixed ? fixed_res : r);
        // Bursts of random length, separated by random gaps
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic wait_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_literals.size() != 0)
            @(posedge clk);
    endtask

    // A long digit string of the given consumed length, optionally with a leading minus
    task automatic long_literal(input int total, input bit neg);
        int n;
        n = total;
        if (neg)
        begin
            send_char(CH_MINUS, 1'b1);
            n--;
            send_char(rand_digit(), 1'b0);
        end
        else
            send_char(rand_digit(), 1'b1);
        repeat (n - 1)
            send_char(rand_digit(), 1'b0);
        send_char(CH_NUL, 1'b0);
    endtask

    // Mostly well-formed literal with random content and random shape
    task automatic gen_literal();
        logic s;
        s = 1'b1;
        if ($urandom_range(0, 3) == 0)
        begin
            send_char(CH_MINUS, s);
            s = 1'b0;
        end
        repeat ($urandom_range(0, 4))
        begin
            send_char(rand_digit(), s);
            s = 1'b0;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            send_char(CH_DOT, s);
            s = 1'b0;
            repeat ($urandom_range(0, 3))
                send_char(rand_digit(), 1'b0);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            send_char($urandom_range(0, 1) ? CH_E_LO : CH_E_UP, s);
            s = 1'b0;
            case ($urandom_range(0, 3))
                1: send_char(CH_MINUS, 1'b0);
                2: send_char(CH_PLUS, 1'b0);
                3:
                begin
                    send_char(CH_MINUS, 1'b0);
                    send_char(CH_PLUS, 1'b0);
                end
                default: ;
            endcase
            repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3))
                send_char(rand_digit(), 1'b0);
        end
        send_char(pick_stop(), s);
    endtask

    // Random run of literal characters; sometimes left open for the next start to abandon
    task automatic gen_broken();
        logic s;
        s = 1'b1;
        repeat ($urandom_range(1, 10))
        begin
            send_char(pick_scan_char(), s);
            s = 1'b0;
        end
        if ($urandom_range(0, 4) != 0)
            send_char(pick_stop(), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                // Hold the output off for a long stretch so the block backs up
                out_stall <= 1'b1;
                hold_left--;
                if (hold_left == 0)
                    hold_done = 1'b1;
            end
            else if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                hold_left = HOLD_CYCLES;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 100);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    default: out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lit_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (matched)
                n_accepted++;
            if (too_long)
                n_overlong++;
            if (expected_literals.size() == 0)
            begin
                $display("%0t: result with nothing expected: literal_len %0d matched %0b too_long %0b",
                         $time, literal_len, matched, too_long);
                errors++;
            end
            else
            begin
                want = expected_literals.pop_front();
                if (literal_len !== want.len)
                begin
                    $display("%0t: literal_len expected %0d actual %0d",
                             $time, want.len, literal_len);
                    errors++;
                end
                if (matched !== want.matched)
                begin
                    $display("%0t: matched expected %0b actual %0b",
                             $time, want.matched, matched);
                    errors++;
                end
                if (too_long !== want.too_long)
                begin
                    $display("%0t: too_long expected %0b actual %0b",
                             $time, want.too_long, too_long);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if the stream never drains
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, expected_literals.size());
        $display("decimal_float_literal_recognizer test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        lit_result_t typed;
        int          base;
        int          pick;
        bit          paused;

        lx_scanning = 1'b0;
        clear_scan();
        for (int j = 0; j < PATTERN_SLOTS; j++)
            lx_slots[j] = 3'd0;

        // Directed table: ch, start, typed?, len, matched, too_long
        dir_rows = '{
            // idle byte with every bit set, no scan open: ignored
            '{CH_ALL_ONES, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            // immediate end on NUL and on an all-ones byte
            '{CH_NUL,      1'b1, 1'b1, 8'd0, 1'b0, 1'b0},
            '{CH_ALL_ONES, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0},
            // lone minus is rejected
            '{CH_MINUS,    1'b1, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_NUL,      1'b0, 1'b1, 8'd0, 1'b0, 1'b0},
            // lone dot is accepted
            '{CH_DOT,      1'b1, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_NUL,      1'b0, 1'b1, 8'd1, 1'b1, 1'b0},
            // every operation in one literal: minus, digits, dot, exponent, both signs
            '{CH_MINUS,    1'b1, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_DIGIT_1,  1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_DOT,      1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_DIGIT_5,  1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_E_LO,     1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_MINUS,    1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_PLUS,     1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_NINE,     1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_SPACE,    1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            // restart mid-scan abandons "9E+0"; the new scan is a bare exponent
            '{CH_NINE,     1'b1, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_E_UP,     1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_PLUS,     1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_ZERO,     1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_E_LO,     1'b1, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_LETTER_X, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            // terminator does not open a scan: this digit is ignored
            '{CH_DIGIT_7,  1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
            // single digit
            '{CH_DIGIT_3,  1'b1, 1'b0, 8'd0, 1'b0, 1'b0},
            '{CH_NUL,      1'b0, 1'b1, 8'd1, 1'b1, 1'b0}
        };

        // Reset once
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            typed = '{dir_rows[k].len, dir_rows[k].matched, dir_rows[k].too_long};
            send_char(dir_rows[k].ch, dir_rows[k].st, dir_rows[k].typed, typed);
        end
        wait_empty();

        // Length extremes around the overlong boundary
        long_literal(254, 1'b0);
        long_literal(255, 1'b0);
        long_literal(255, 1'b1);
        long_literal(256, 1'b0);
        long_literal(300, 1'b1);

        // Random part: mostly well-formed literals, some broken runs and raw noise
        base   = n_live;
        paused = 1'b0;
        while (n_live - base < RANDOM_ITEMS)
        begin
            if (!hold_req && n_live - base > 150)
                hold_req <= 1'b1;
            if (!paused && n_live - base > 300)
            begin
                wait_empty();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
                gen_literal();
            else if (pick < 90)
                gen_broken();
            else
                repeat ($urandom_range(1, 5))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end

        wait_empty();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d live characters; checked %0d results (%0d accepted, %0d overlong).",
                 n_live, n_results, n_accepted, n_overlong);
        $display("Covered immediate end, lone minus and dot, restart, exponent signs, length limit.");
        if (errors == 0 && expected_literals.size() == 0)
            $display("decimal_float_literal_recognizer test passed");
        else
            $display("decimal_float_literal_recognizer test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/dflr_pkg.sv
hw/rtl/decimal_float_literal_recognizer.sv
tb/sv/tb_decimal_float_literal_recognizer.sv
